// ----- design/tnfc_pkg.sv -----
package tnfc_pkg;

  // Default topic length limit in characters
  localparam int unsigned MAX_TOPIC_LEN_DEF = 256;

  // Width of the reported kept length
  localparam int unsigned KEPT_LEN_W = 9;

  // Characters with a special meaning in topics
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // Rule set selected by the operation bit
  localparam logic OP_PUBLISH   = 1'b0;
  localparam logic OP_SUBSCRIBE = 1'b1;

  // Input beat: one character of a topic
  typedef struct packed {
    logic [7:0] topic_byte;
    logic       has_char;
    logic       is_last;
    logic       operation;
  } item_t;

  // Result beat: verdict for one topic
  typedef struct packed {
    logic                  verdict;
    logic [KEPT_LEN_W-1:0] kept_length;
  } result_t;

  // Result handed from the scan stage to the output register
  typedef struct packed {
    logic    valid;
    result_t result;
  } res_beat_t;

endpackage

// ----- design/tnfc_in_stage.sv -----
module tnfc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tnfc_pkg::item_t in_item,
  input  logic            adv,
  output logic            s1_valid,
  output tnfc_pkg::item_t s1_item
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  tnfc_pkg::item_t s1_item_r;
  logic            load;

  // Hold the upstream side while the registered beat cannot move on
  assign in_stall = s1_valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the payload of each accepted beat
  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ----- design/tnfc_scan.sv -----
module tnfc_scan #(
  parameter int unsigned MAX_TOPIC_LEN = tnfc_pkg::MAX_TOPIC_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  tnfc_pkg::item_t     s1_item,
  input  logic                out_free,
  output logic                adv,
  output tnfc_pkg::res_beat_t res
);

  localparam int unsigned CNT_W = $clog2(MAX_TOPIC_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOPIC_LEN);

  logic [CNT_W-1:0] raw_cnt_r, raw_cnt_nxt;
  logic             lead_r, lead_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             need_soe_r, need_soe_nxt;
  logic             need_end_r, need_end_nxt;
  logic             err_r, err_nxt;
  logic             mode_r, mode_nxt;

  logic             cnt_zero;
  logic             has;
  logic             lead_drop;
  logic             kept;
  logic             lvl_start;
  logic [7:0]       c;
  logic [7:0]       last_char;
  logic [CNT_W-1:0] len0, len1, len2;
  logic             bad;

  assign c = s1_item.topic_byte;

  // Move on unless a verdict is due and the output register is full
  assign adv = s1_valid && (!s1_item.is_last || out_free);

  // Update the per-topic flags for the current character
  always_comb begin
    cnt_zero     = (raw_cnt_r == '0);
    mode_nxt     = cnt_zero ? s1_item.operation : mode_r;
    has          = s1_item.has_char && (c != tnfc_pkg::CH_NONE);
    lead_drop    = has && cnt_zero && (c == tnfc_pkg::CH_SLASH);
    kept         = has && !lead_drop;
    lvl_start    = (prev_r == tnfc_pkg::CH_NONE) || (prev_r == tnfc_pkg::CH_SLASH);

    lead_nxt     = lead_r || lead_drop;
    prev_nxt     = prev_r;
    need_soe_nxt = need_soe_r;
    need_end_nxt = need_end_r;
    err_nxt      = err_r;

    if (kept) begin
      if (mode_nxt == tnfc_pkg::OP_PUBLISH) begin
        if (c == tnfc_pkg::CH_PLUS || c == tnfc_pkg::CH_HASH) begin
          err_nxt = 1'b1;
        end
      end else begin
        if (c[7]) begin
          err_nxt = 1'b1;
        end
        if (need_end_r) begin
          // only the dropped trailing slash may follow a hash
          if (!(c == tnfc_pkg::CH_SLASH && prev_r == tnfc_pkg::CH_HASH)) begin
            err_nxt = 1'b1;
          end
        end else if (need_soe_r) begin
          if (c != tnfc_pkg::CH_SLASH) begin
            err_nxt = 1'b1;
          end
          need_soe_nxt = 1'b0;
        end
        if (c == tnfc_pkg::CH_PLUS) begin
          if (!lvl_start) begin
            err_nxt = 1'b1;
          end
          need_soe_nxt = 1'b1;
        end else if (c == tnfc_pkg::CH_HASH) begin
          if (!lvl_start) begin
            err_nxt = 1'b1;
          end
          need_end_nxt = 1'b1;
        end
      end
      prev_nxt = c;
    end

    // Count characters, saturating one above the limit
    raw_cnt_nxt = raw_cnt_r;
    if (has && raw_cnt_r <= CNT_MAX) begin
      raw_cnt_nxt = raw_cnt_r + 1'b1;
    end
  end

  // Form the verdict from the updated state
  always_comb begin
    last_char = has ? c : prev_r;
    len0      = raw_cnt_nxt;
    len1      = len0 - CNT_W'(lead_nxt);
    len2      = len1 - CNT_W'(last_char == tnfc_pkg::CH_SLASH);
    bad       = err_nxt || (len0 == '0) || (len0 > CNT_MAX) || (len1 == '0) ||
                (len2 == '0);
    res.valid              = adv && s1_item.is_last;
    res.result.verdict     = bad;
    res.result.kept_length = bad ? '0 : tnfc_pkg::KEPT_LEN_W'(len2);
  end

  // Advance the state on each consumed beat; clear it after a verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_cnt_r  <= '0;
      lead_r     <= 1'b0;
      prev_r     <= tnfc_pkg::CH_NONE;
      need_soe_r <= 1'b0;
      need_end_r <= 1'b0;
      err_r      <= 1'b0;
      mode_r     <= 1'b0;
    end else if (adv) begin
      if (s1_item.is_last) begin
        raw_cnt_r  <= '0;
        lead_r     <= 1'b0;
        prev_r     <= tnfc_pkg::CH_NONE;
        need_soe_r <= 1'b0;
        need_end_r <= 1'b0;
        err_r      <= 1'b0;
        mode_r     <= 1'b0;
      end else begin
        raw_cnt_r  <= raw_cnt_nxt;
        lead_r     <= lead_nxt;
        prev_r     <= prev_nxt;
        need_soe_r <= need_soe_nxt;
        need_end_r <= need_end_nxt;
        err_r      <= err_nxt;
        mode_r     <= mode_nxt;
      end
    end
  end

  // Counter never runs past its saturation point
  assert property (@(posedge clk) disable iff (!rst_n)
    raw_cnt_r <= CNT_MAX + 1'b1)
    else $error("character count above saturation");

  // A consumed last beat leaves a clean topic state behind
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item.is_last |=> raw_cnt_r == '0 && !err_r && !lead_r)
    else $error("topic state not cleared after verdict");

  // Level flags are only set under subscribe rules
  assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == tnfc_pkg::OP_PUBLISH |-> !need_soe_r && !need_end_r)
    else $error("wildcard flag set under publish rules");

  // No error, leading slash or previous character is recorded before the first character is counted
  assert property (@(posedge clk) disable iff (!rst_n)
    raw_cnt_r == '0 |-> !err_r && !lead_r && prev_r == tnfc_pkg::CH_NONE)
    else $error("topic state set with no character counted");

endmodule

// ----- design/tnfc_out_stage.sv -----
module tnfc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  tnfc_pkg::res_beat_t res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output tnfc_pkg::result_t   out_result
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  tnfc_pkg::result_t out_result_r;

  // Room for a new result when empty or when the held beat leaves now
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the payload only with a new result
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_result_r <= res.result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- design/topic_name_filter_checker.sv -----
// Topic name / topic filter checker.
// Input channel (in_valid, in_stall, in_item): one beat per topic character;
// has_char low marks a beat without a character, is_last closes the topic.
// The operation bit of the first character beat picks publish or subscribe
// rules. Output channel (out_valid, out_stall, out_result): one beat per
// closed topic with the verdict (1 = invalid) and the kept length after
// dropping one leading and one trailing slash (0 when invalid).
// A last beat passes from the input register through the combinational
// scan into the result register, where it raises out_valid.
// Throughput: one input beat per cycle while in_stall is low; all checks
// are combinational flag updates between the two registers.
// When out_stall holds a result, beats without is_last still flow through;
// a last beat waits in the input register and in_stall rises behind it.
// Reset (rst_n low, synchronous) empties both registers and clears the
// per-topic state; the first beat may be taken in the cycle after reset.
module topic_name_filter_checker #(
  parameter int unsigned MAX_TOPIC_LEN = tnfc_pkg::MAX_TOPIC_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tnfc_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output tnfc_pkg::result_t out_result
);

  logic                s1_valid;
  tnfc_pkg::item_t     s1_item;
  logic                adv;
  logic                out_free;
  tnfc_pkg::res_beat_t res;

  tnfc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tnfc_scan #(
    .MAX_TOPIC_LEN (MAX_TOPIC_LEN)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .out_free (out_free),
    .adv      (adv),
    .res      (res)
  );

  tnfc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

endmodule

// ----- sim/tb_topic_name_filter_checker.sv -----
module tb_topic_name_filter_checker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOPIC_MAX    = tnfc_pkg::MAX_TOPIC_LEN_DEF;
  localparam logic [7:0]  ASCII_TOP    = 8'd127;
  localparam logic [7:0]  CH_LOW_A     = 8'h61;
  localparam logic [7:0]  CH_LOW_Z     = 8'h7A;
  localparam int unsigned RANDOM_BEATS = 400;
  localparam int unsigned STALE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 30;
  localparam int unsigned PAUSE_TOPIC  = 12;
  localparam int unsigned DIR_ROWS     = 32;
  localparam int unsigned SHOW_ERRORS  = 10;

  // One line of the directed stimulus: a beat repeated reps times
  typedef struct packed {
    tnfc_pkg::item_t   beat;
    logic [8:0]        reps;
    logic              typed;
    tnfc_pkg::result_t want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  tnfc_pkg::item_t   in_item;
  logic              out_valid;
  logic              out_stall;
  tnfc_pkg::result_t out_result;

  topic_name_filter_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Topic scan state mirrored from the block
  int unsigned chars_seen;
  logic        lead_dropped;
  logic [7:0]  last_kept;
  logic        want_slash;
  logic        want_end;
  logic        topic_bad;
  logic        topic_mode;

  tnfc_pkg::result_t verdicts_due[$];
  tnfc_pkg::item_t   topic_q[$];
  logic [7:0]        text_q[$];
  dir_row_t          dir_rows[DIR_ROWS];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned beats_sent;
  bit          long_hold;
  bit          tx_quiet;

  function automatic void clear_topic();
    chars_seen   = 0;
    lead_dropped = 1'b0;
    last_kept    = tnfc_pkg::CH_NONE;
    want_slash   = 1'b0;
    want_end     = 1'b0;
    topic_bad    = 1'b0;
    topic_mode   = tnfc_pkg::OP_PUBLISH;
  endfunction

  // Apply the publish or subscribe rules to one kept character
  function automatic void keep_char(logic [7:0] ch);
    logic level_start;
    level_start = (last_kept == tnfc_pkg::CH_NONE) || (last_kept == tnfc_pkg::CH_SLASH);
    if (topic_mode == tnfc_pkg::OP_PUBLISH) begin
      if (ch == tnfc_pkg::CH_PLUS || ch == tnfc_pkg::CH_HASH) topic_bad = 1'b1;
    end else begin
      if (ch > ASCII_TOP) topic_bad = 1'b1;
      if (want_end) begin
        if (!(ch == tnfc_pkg::CH_SLASH && last_kept == tnfc_pkg::CH_HASH)) topic_bad = 1'b1;
      end else if (want_slash) begin
        if (ch != tnfc_pkg::CH_SLASH) topic_bad = 1'b1;
        want_slash = 1'b0;
      end
      if (ch == tnfc_pkg::CH_PLUS) begin
        if (!level_start) topic_bad = 1'b1;
        want_slash = 1'b1;
      end else if (ch == tnfc_pkg::CH_HASH) begin
        if (!level_start) topic_bad = 1'b1;
        want_end = 1'b1;
      end
    end
    last_kept = ch;
  endfunction

  // Advance the topic state by one beat; return 1 with the verdict on a last beat
  function automatic bit track_topic(input tnfc_pkg::item_t it,
                                     output tnfc_pkg::result_t res);
    logic        has;
    logic [7:0]  tail;
    int unsigned len;
    logic        bad;
    has = it.has_char && (it.topic_byte != tnfc_pkg::CH_NONE);
    res = '0;
    if (chars_seen == 0) topic_mode = it.operation;
    if (has) begin
      if (chars_seen == 0 && it.topic_byte == tnfc_pkg::CH_SLASH) lead_dropped = 1'b1;
      else keep_char(it.topic_byte);
      if (chars_seen <= TOPIC_MAX) chars_seen++;
    end
    if (!it.is_last) return 1'b0;
    tail = has ? it.topic_byte : last_kept;
    len  = chars_seen;
    bad  = topic_bad;
    if (len == 0 || len > TOPIC_MAX) begin
      bad = 1'b1;
    end else begin
      if (lead_dropped) len--;
      if (len == 0) begin
        bad = 1'b1;
      end else begin
        if (tail == tnfc_pkg::CH_SLASH) len--;
        if (len == 0) bad = 1'b1;
      end
    end
    res.verdict     = bad;
    res.kept_length = bad ? '0 : len[tnfc_pkg::KEPT_LEN_W-1:0];
    clear_topic();
    return 1'b1;
  endfunction

  function automatic dir_row_t dir_entry(logic [7:0] ch, logic has, logic last, logic op,
                                         int unsigned reps, logic typed, logic bad,
                                         int unsigned len);
    dir_row_t r;
    r.beat.topic_byte  = ch;
    r.beat.has_char    = has;
    r.beat.is_last     = last;
    r.beat.operation   = op;
    r.reps             = reps[8:0];
    r.typed            = typed;
    r.want.verdict     = bad;
    r.want.kept_length = len[tnfc_pkg::KEPT_LEN_W-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_gap(bit quiet);
    if (quiet) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 16);
    return $urandom_range(0, 2);
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= SHOW_ERRORS) $display("%s", msg);
  endfunction

  // Offer one beat, hold it until taken, then queue its verdict if it closes a topic
  task automatic send_beat(input tnfc_pkg::item_t it, input logic typed,
                           input tnfc_pkg::result_t want);
    int unsigned       gap;
    tnfc_pkg::result_t res;
    gap = long_hold ? 0 : draw_gap(tx_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (track_topic(it, res)) verdicts_due.push_back(typed ? want : res);
    beats_sent++;
  endtask

  // Drop valid and wait until every pending verdict has come back
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  // Build one random topic and split it into beats
  task automatic build_topic();
    logic            op;
    int unsigned     style;
    int unsigned     nlev;
    int unsigned     wlen;
    int unsigned     pick;
    logic [7:0]      ch;
    tnfc_pkg::item_t it;
    text_q.delete();
    topic_q.delete();
    op    = 1'($urandom_range(0, 1));
    style = $urandom_range(0, 99);
    if (style < 5) begin
      // no characters at all
    end else if (style == 5) begin
      // near or past the length limit
      wlen = $urandom_range(TOPIC_MAX - 3, TOPIC_MAX + 3);
      repeat (wlen) begin
        ch = ($urandom_range(0, 15) == 0) ? tnfc_pkg::CH_SLASH
                                          : 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
        text_q.push_back(ch);
      end
    end else if (style < 75) begin
      // well-formed levels with random content
      if ($urandom_range(0, 3) == 0) text_q.push_back(tnfc_pkg::CH_SLASH);
      nlev = $urandom_range(1, 4);
      for (int l = 0; l < nlev; l++) begin
        if (l != 0) text_q.push_back(tnfc_pkg::CH_SLASH);
        pick = $urandom_range(0, 9);
        if (op == tnfc_pkg::OP_SUBSCRIBE && pick < 2) begin
          text_q.push_back(tnfc_pkg::CH_PLUS);
        end else if (op == tnfc_pkg::OP_SUBSCRIBE && pick == 2 && l == nlev - 1) begin
          text_q.push_back(tnfc_pkg::CH_HASH);
        end else if (op == tnfc_pkg::OP_PUBLISH && pick == 0) begin
          text_q.push_back($urandom_range(0, 1) ? tnfc_pkg::CH_PLUS : tnfc_pkg::CH_HASH);
        end else begin
          wlen = $urandom_range(1, 4);
          repeat (wlen) begin
            ch = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(ASCII_TOP + 1, 255))
                                              : 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
            text_q.push_back(ch);
          end
        end
      end
      if ($urandom_range(0, 3) == 0) text_q.push_back(tnfc_pkg::CH_SLASH);
    end else begin
      // raw bytes heavy in special characters
      wlen = $urandom_range(1, 10);
      repeat (wlen) begin
        case ($urandom_range(0, 5))
          0:       ch = tnfc_pkg::CH_SLASH;
          1:       ch = tnfc_pkg::CH_PLUS;
          2:       ch = tnfc_pkg::CH_HASH;
          default: ch = 8'($urandom_range(0, 255));
        endcase
        text_q.push_back(ch);
      end
    end

    foreach (text_q[k]) begin
      if ($urandom_range(0, 9) == 0) begin
        it.topic_byte = 8'($urandom_range(0, 255));
        it.has_char   = 1'b0;
        it.is_last    = 1'b0;
        it.operation  = 1'($urandom_range(0, 1));
        topic_q.push_back(it);
      end
      it.topic_byte = text_q[k];
      it.has_char   = 1'b1;
      it.is_last    = 1'b0;
      it.operation  = ($urandom_range(0, 7) == 0) ? !op : op;
      topic_q.push_back(it);
    end
    // close with an empty beat now and then, always when there are no characters
    if (topic_q.size() == 0 || $urandom_range(0, 9) == 0) begin
      it.topic_byte = 8'($urandom_range(0, 255));
      it.has_char   = 1'b0;
      it.is_last    = 1'b0;
      it.operation  = op;
      topic_q.push_back(it);
    end
    it = topic_q.pop_back();
    it.is_last = 1'b1;
    topic_q.push_back(it);
  endtask

  // Result side: random stalls, one long hold, compare against the oldest verdict
  initial begin : result_sink
    int unsigned       gap;
    bit                held_once;
    bit                rx_quiet;
    tnfc_pkg::result_t want;
    out_stall <= 1'b0;
    held_once = 1'b0;
    rx_quiet  = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_once && results_seen == HOLD_AFTER) begin
        held_once = 1'b1;
        long_hold = 1'b1;
        gap       = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
        gap = draw_gap(rx_quiet);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      long_hold = 1'b0;
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (verdicts_due.size() == 0) begin
        flag_error($sformatf("unexpected result beat: verdict %0d length %0d",
                             out_result.verdict, out_result.kept_length));
      end else begin
        want = verdicts_due.pop_front();
        if (out_result.verdict !== want.verdict ||
            out_result.kept_length !== want.kept_length)
          flag_error($sformatf("result %0d: verdict exp %0d got %0d, length exp %0d got %0d",
                               results_seen, want.verdict, out_result.verdict,
                               want.kept_length, out_result.kept_length));
      end
      results_seen++;
    end
  end

  // End the run when neither channel moves for too long
  initial begin : stall_watch
    int unsigned stale;
    stale = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    while (stale < STALE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stale = 0;
      else stale++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned topic_no;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_item      <= '0;
    mismatches   = 0;
    results_seen = 0;
    beats_sent   = 0;
    long_hold    = 1'b0;
    tx_quiet     = 1'b0;
    clear_topic();

    // empty topic, extremes of the byte, zero byte, slash stripping
    dir_rows[0]  = dir_entry("x", 1'b0, 1'b1, tnfc_pkg::OP_PUBLISH, 1, 1'b1, 1'b1, 0);
    dir_rows[1]  = dir_entry("a", 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1, 1'b1, 1'b0, 1);
    dir_rows[2]  = dir_entry(8'h01, 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1, 1'b1, 1'b0, 1);
    dir_rows[3]  = dir_entry(8'hFF, 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1, 1'b1, 1'b0, 1);
    dir_rows[4]  = dir_entry(8'hFF, 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1, 1'b1, 1'b1, 0);
    dir_rows[5]  = dir_entry(tnfc_pkg::CH_NONE, 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b1, 1'b1, 0);
    dir_rows[6]  = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1,
                             1'b1, 1'b1, 0);
    dir_rows[7]  = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b0, tnfc_pkg::OP_PUBLISH, 1,
                             1'b0, 1'b0, 0);
    dir_rows[8]  = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1,
                             1'b1, 1'b1, 0);
    // wildcards under both rule sets
    dir_rows[9]  = dir_entry(tnfc_pkg::CH_PLUS, 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1,
                             1'b1, 1'b1, 0);
    dir_rows[10] = dir_entry(tnfc_pkg::CH_HASH, 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1,
                             1'b1, 1'b1, 0);
    dir_rows[11] = dir_entry(tnfc_pkg::CH_HASH, 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b1, 1'b0, 1);
    dir_rows[12] = dir_entry(tnfc_pkg::CH_PLUS, 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b1, 1'b0, 1);
    // slash right after a hash, then end of topic
    dir_rows[13] = dir_entry(tnfc_pkg::CH_HASH, 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    dir_rows[14] = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    // plus filling a middle level
    dir_rows[15] = dir_entry("a", 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1, 1'b0, 1'b0, 0);
    dir_rows[16] = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    dir_rows[17] = dir_entry(tnfc_pkg::CH_PLUS, 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    dir_rows[18] = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    dir_rows[19] = dir_entry("b", 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1, 1'b0, 1'b0, 0);
    // mode comes from the first character beat, not from an empty beat ahead of it
    dir_rows[20] = dir_entry("z", 1'b0, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1, 1'b0, 1'b0, 0);
    dir_rows[21] = dir_entry("a", 1'b1, 1'b0, tnfc_pkg::OP_PUBLISH, 1, 1'b0, 1'b0, 0);
    dir_rows[22] = dir_entry(tnfc_pkg::CH_PLUS, 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    // character after a hash
    dir_rows[23] = dir_entry(tnfc_pkg::CH_HASH, 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    dir_rows[24] = dir_entry("a", 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1, 1'b0, 1'b0, 0);
    // overlong topic, then exactly at the limit with and without slashes
    dir_rows[25] = dir_entry("a", 1'b1, 1'b0, tnfc_pkg::OP_PUBLISH, TOPIC_MAX + 1,
                             1'b0, 1'b0, 0);
    dir_rows[26] = dir_entry("x", 1'b0, 1'b1, tnfc_pkg::OP_PUBLISH, 1, 1'b1, 1'b1, 0);
    dir_rows[27] = dir_entry("a", 1'b1, 1'b0, tnfc_pkg::OP_PUBLISH, TOPIC_MAX - 1,
                             1'b0, 1'b0, 0);
    dir_rows[28] = dir_entry("b", 1'b1, 1'b1, tnfc_pkg::OP_PUBLISH, 1, 1'b1, 1'b0,
                             TOPIC_MAX);
    dir_rows[29] = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b0, 1'b0, 0);
    dir_rows[30] = dir_entry("a", 1'b1, 1'b0, tnfc_pkg::OP_SUBSCRIBE, TOPIC_MAX - 2,
                             1'b0, 1'b0, 0);
    dir_rows[31] = dir_entry(tnfc_pkg::CH_SLASH, 1'b1, 1'b1, tnfc_pkg::OP_SUBSCRIBE, 1,
                             1'b1, 1'b0, TOPIC_MAX - 2);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed rows
    for (int i = 0; i < DIR_ROWS; i++)
      for (int r = 0; r < dir_rows[i].reps; r++)
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    drain_verdicts();

    // random topics, with one full pause partway through
    beats_sent = 0;
    topic_no   = 0;
    while (beats_sent < RANDOM_BEATS) begin
      build_topic();
      if (topic_no == PAUSE_TOPIC) drain_verdicts();
      if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
      foreach (topic_q[k]) send_beat(topic_q[k], 1'b0, '0);
      topic_no++;
    end
    drain_verdicts();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tnfc_pkg.sv
design/tnfc_in_stage.sv
design/tnfc_scan.sv
design/tnfc_out_stage.sv
design/topic_name_filter_checker.sv
sim/tb_topic_name_filter_checker.sv
